// File: rtl/tcsw_pkg.sv
// Shared types and character codes for the text console screen writer.
// Used by every module in rtl except tcsw_step_unit; depends on nothing.
package tcsw_pkg;

  typedef logic [15:0] cell_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] char_code;
    logic [7:0] attribute;
    logic [10:0] cell_address;
  } req_t;

  typedef struct packed {
    logic [4:0] cursor_row;
    logic [6:0] cursor_column;
    cell_t      cell_data;
  } rsp_t;

  localparam logic MODE_PUT  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  localparam logic [7:0] CH_BS       = 8'd8;
  localparam logic [7:0] CH_TAB      = 8'd9;
  localparam logic [7:0] CH_LF       = 8'd10;
  localparam logic [7:0] CH_VT       = 8'd11;
  localparam logic [7:0] CH_FF       = 8'd12;
  localparam logic [7:0] CH_CR       = 8'd13;
  localparam logic [7:0] CH_SPACE    = 8'd32;
  localparam logic [7:0] CH_PRINT_LO = 8'd32;
  localparam logic [7:0] CH_PRINT_HI = 8'd126;

  localparam int TAB_STOP_BITS = 3;

endpackage

// File: rtl/text_console_screen_writer.sv
// Top level of the text console screen writer: request handshake, result register.
// Depends on tcsw_pkg, tcsw_seq (with tcsw_step_unit) and tcsw_screen_ram.
//
//   Channel  Handshake            Payload
//   request  in_valid / in_stall  mode, char_code, attribute, cell_address
//   result   out_valid/out_stall  cursor_row, cursor_column, cell_data
//
// A tab writes its spaces one after another through the fill walk.
// Form feed and a scroll each walk all ROWS*COLUMNS cells, plus the spaces of a tab that causes
// the scroll; these walks through the single write port set the worst case.
// After reset a clearing pass writes zero to all ROWS*COLUMNS cells before the
// first request is taken. A stalled result holds; the next request is taken
// once the current one has reached the result register.
module text_console_screen_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            mode,
  input  logic [7:0]      char_code,
  input  logic [7:0]      attribute,
  input  logic [10:0]     cell_address,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [4:0]      cursor_row,
  output logic [6:0]      cursor_column,
  output tcsw_pkg::cell_t cell_data
);
  import tcsw_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int IW    = $clog2(CELLS);

  req_t    req;
  rsp_t    rsp;
  logic    seq_idle;
  logic    seq_done;
  logic    start;
  logic    out_free;
  logic    ram_we;
  logic [IW-1:0] ram_waddr;
  cell_t   ram_wdata;
  logic [IW-1:0] ram_raddr;
  cell_t   ram_rdata;

  always_comb begin
    req.mode         = mode;
    req.char_code    = char_code;
    req.attribute    = attribute;
    req.cell_address = cell_address;
  end

  assign in_stall = !seq_idle;
  assign start    = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  tcsw_seq #(.COLUMNS(COLUMNS), .ROWS(ROWS), .IW(IW)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req_in    (req),
    .idle      (seq_idle),
    .done      (seq_done),
    .out_free  (out_free),
    .rsp       (rsp),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  tcsw_screen_ram #(.DEPTH(CELLS), .IW(IW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (seq_done && out_free) begin
      out_valid     <= 1'b1;
      cursor_row    <= rsp.cursor_row;
      cursor_column <= rsp.cursor_column;
      cell_data     <= rsp.cell_data;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: rtl/tcsw_step_unit.sv
// Shared pointer step unit: increments the walk pointer and compares it
// against the end of the current walk. No package dependencies.
module tcsw_step_unit #(
  parameter int AW = 11
) (
  input  logic [AW-1:0] ptr,
  input  logic [AW-1:0] limit,
  output logic [AW-1:0] ptr_inc,
  output logic          ptr_hit
);

  assign ptr_inc = ptr + AW'(1);
  assign ptr_hit = (ptr_inc == limit);

endmodule

// File: rtl/tcsw_seq.sv
// Command sequencer: cursor state, byte decode, fill, scroll and clear walks.
// Depends on tcsw_pkg and tcsw_step_unit; drives the screen memory ports.
module tcsw_seq #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  parameter int IW      = 11
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  tcsw_pkg::req_t  req_in,
  output logic            idle,
  output logic            done,
  input  logic            out_free,
  output tcsw_pkg::rsp_t  rsp,
  output logic            ram_we,
  output logic [IW-1:0]   ram_waddr,
  output tcsw_pkg::cell_t ram_wdata,
  output logic [IW-1:0]   ram_raddr,
  input  tcsw_pkg::cell_t ram_rdata
);
  import tcsw_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS + 1);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS + 1);

  localparam logic [AW-1:0] CELLS_A    = AW'(CELLS);
  localparam logic [AW-1:0] COLS_A     = AW'(COLUMNS);
  localparam logic [AW-1:0] LAST_ROW_A = AW'(CELLS - COLUMNS);
  localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);
  localparam logic [CW-1:0] COLS_C     = CW'(COLUMNS);
  localparam logic [CW:0]   COLS_X     = (CW + 1)'(COLUMNS);
  localparam logic [CW:0]   TAB_MASK   = (CW + 1)'((1 << TAB_STOP_BITS) - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_READ, S_POST, S_FILL, S_SCROLL, S_SCROLL_LAST, S_DONE
  } state_t;

  state_t        state;
  state_t        fill_ret;
  req_t          req;
  logic [RW-1:0] row;
  logic [CW-1:0] col;
  logic [AW-1:0] base;
  logic [AW-1:0] ptr;
  logic [AW-1:0] fill_end;
  cell_t         fill_data;
  logic [AW-1:0] lag_addr;
  logic          lag_valid;
  logic          adv;
  cell_t         data;

  logic [AW-1:0] step_limit;
  logic [AW-1:0] ptr_inc;
  logic          ptr_hit;

  cell_t         blank;
  logic [AW-1:0] cur_addr;
  logic [AW-1:0] bs_addr;
  logic [AW-1:0] lag_dst;
  logic [CW:0]   next_stop;
  logic [CW-1:0] col_tab;
  logic [AW-1:0] tab_end;
  logic [31:0]   rd_wide;
  logic          rd_in_range;
  logic          printable;
  logic          wrap;
  logic [31:0]   row_wide;
  logic [31:0]   col_wide;

  tcsw_step_unit #(.AW(AW)) u_step (
    .ptr     (ptr),
    .limit   (step_limit),
    .ptr_inc (ptr_inc),
    .ptr_hit (ptr_hit)
  );

  assign step_limit = (state == S_FILL) ? fill_end : CELLS_A;

  assign blank       = {req.attribute, CH_SPACE};
  assign cur_addr    = base + AW'(col);
  assign bs_addr     = cur_addr - AW'(1);
  assign lag_dst     = lag_addr - COLS_A;
  assign next_stop   = ({1'b0, col} | TAB_MASK) + (CW + 1)'(1);
  assign col_tab     = (next_stop >= COLS_X) ? COLS_C : next_stop[CW-1:0];
  assign tab_end     = base + AW'(col_tab);
  assign rd_wide     = 32'(req.cell_address);
  assign rd_in_range = (rd_wide < 32'(CELLS));
  assign printable   = (req.char_code >= CH_PRINT_LO) && (req.char_code <= CH_PRINT_HI);
  assign wrap        = (col == COLS_C);

  assign idle = (state == S_IDLE);
  assign done = (state == S_DONE);

  assign row_wide          = 32'(row);
  assign col_wide          = 32'(col);
  assign rsp.cursor_row    = row_wide[4:0];
  assign rsp.cursor_column = col_wide[6:0];
  assign rsp.cell_data     = data;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr[IW-1:0];
    ram_wdata = fill_data;
    ram_raddr = ptr[IW-1:0];
    unique case (state)
      S_EXEC: begin
        ram_raddr = rd_wide[IW-1:0];
        if (req.mode == MODE_PUT) begin
          if (req.char_code == CH_BS) begin
            if (col != '0) begin
              ram_we    = 1'b1;
              ram_waddr = bs_addr[IW-1:0];
              ram_wdata = blank;
            end
          end else if (printable) begin
            ram_we    = 1'b1;
            ram_waddr = cur_addr[IW-1:0];
            ram_wdata = {req.attribute, req.char_code};
          end
        end
      end
      S_FILL: begin
        ram_we = 1'b1;
      end
      S_SCROLL, S_SCROLL_LAST: begin
        ram_we    = lag_valid;
        ram_waddr = lag_dst[IW-1:0];
        ram_wdata = ram_rdata;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FILL;
      fill_ret  <= S_IDLE;
      ptr       <= '0;
      fill_end  <= CELLS_A;
      fill_data <= '0;
      row       <= '0;
      col       <= '0;
      base      <= '0;
      lag_valid <= 1'b0;
      adv       <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req   <= req_in;
            adv   <= 1'b0;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          data <= '0;
          if (req.mode == MODE_READ) begin
            state <= rd_in_range ? S_READ : S_DONE;
          end else begin
            state <= S_POST;
            unique case (req.char_code)
              CH_LF: begin
                col <= '0;
                adv <= 1'b1;
              end
              CH_CR: begin
                col <= '0;
              end
              CH_TAB: begin
                ptr       <= cur_addr;
                fill_end  <= tab_end;
                fill_data <= blank;
                col       <= col_tab;
                fill_ret  <= S_POST;
                state     <= S_FILL;
              end
              CH_BS: begin
                if (col != '0) begin
                  col <= col - CW'(1);
                end
              end
              CH_FF: begin
                row       <= '0;
                col       <= '0;
                base      <= '0;
                ptr       <= '0;
                fill_end  <= CELLS_A;
                fill_data <= blank;
                fill_ret  <= S_DONE;
                state     <= S_FILL;
              end
              CH_VT: begin
                adv <= 1'b1;
              end
              default: begin
                if (printable) begin
                  col <= col + CW'(1);
                end
              end
            endcase
          end
        end
        S_READ: begin
          data  <= ram_rdata;
          state <= S_DONE;
        end
        S_POST: begin
          if (wrap) begin
            col <= '0;
          end
          if (wrap || adv) begin
            if (row == LAST_ROW) begin
              ptr       <= COLS_A;
              lag_valid <= 1'b0;
              state     <= S_SCROLL;
            end else begin
              row   <= row + RW'(1);
              base  <= base + COLS_A;
              state <= S_DONE;
            end
          end else begin
            state <= S_DONE;
          end
        end
        S_FILL: begin
          ptr <= ptr_inc;
          if (ptr_hit) begin
            state <= fill_ret;
          end
        end
        S_SCROLL: begin
          lag_addr  <= ptr;
          lag_valid <= 1'b1;
          ptr       <= ptr_inc;
          if (ptr_hit) begin
            state <= S_SCROLL_LAST;
          end
        end
        S_SCROLL_LAST: begin
          ptr       <= LAST_ROW_A;
          fill_end  <= CELLS_A;
          fill_data <= blank;
          fill_ret  <= S_DONE;
          state     <= S_FILL;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/tcsw_screen_ram.sv
// Screen cell memory: one write port and one registered read port.
// Depends on tcsw_pkg for the cell type.
module tcsw_screen_ram #(
  parameter int DEPTH = 2000,
  parameter int IW    = 11
) (
  input  logic            clk,
  input  logic            we,
  input  logic [IW-1:0]   waddr,
  input  tcsw_pkg::cell_t wdata,
  input  logic [IW-1:0]   raddr,
  output tcsw_pkg::cell_t rdata
);
  import tcsw_pkg::*;

  cell_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
